>>> rtl/core/mfwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfwm_pkg
// Shared constants for the mains fault window monitor: register map,
// register widths and reset values.
// ----------------------------------------------------------------------------
package mfwm_pkg;

    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 10;
    localparam int HOLD_W       = 10;
    localparam int WINDOW_W     = 4;
    localparam int THRESH_W     = 10;
    localparam int QUALIFY_W    = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TICKS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_LOW    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_HIGH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIP_HIGH    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIP_LOW     = 3'd6;

    localparam logic                RST_ENABLE       = 1'b1;
    localparam logic [HOLD_W-1:0]   RST_HOLD_TICKS   = 10'd700;
    localparam logic [WINDOW_W-1:0] RST_WINDOW_TICKS = 4'd2;
    localparam logic [THRESH_W-1:0] RST_CLEAR_LOW    = 10'd200;
    localparam logic [THRESH_W-1:0] RST_CLEAR_HIGH   = 10'd400;
    localparam logic [THRESH_W-1:0] RST_TRIP_HIGH    = 10'd400;
    localparam logic [THRESH_W-1:0] RST_TRIP_LOW     = 10'd210;

    typedef enum logic
    {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } opcode_t;

endpackage
`default_nettype wire

>>> rtl/core/mfwm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfwm_if
// Valid/ready channels of the mains fault window monitor: input items
// (ticks and ADC samples) and result items (status flags).
// ----------------------------------------------------------------------------
interface mfwm_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    mfwm_pkg::opcode_t      opcode;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   load_safe;
    logic                   temp_safe;

    modport source (output valid, opcode, sample, load_safe, temp_safe, input ready);
    modport sink   (input valid, opcode, sample, load_safe, temp_safe, output ready);
endinterface

interface mfwm_out_if;
    logic valid;
    logic ready;
    logic safe;
    logic fault;
    logic sampling;
    logic fault_event;

    modport source (output valid, safe, fault, sampling, fault_event, input ready);
    modport sink   (input valid, safe, fault, sampling, fault_event, output ready);
endinterface
`default_nettype wire

>>> rtl/core/mains_fault_window_monitor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mains_fault_window_monitor_top
// Mains power-fault monitor: hold timer, sampling window with running peak,
// trip/clear hysteresis over two consecutive windows.
//
// Usage:
//   in_ch  : one transfer per item, opcode 0 = 10 ms tick, 1 = ADC sample.
//   out_ch : exactly one result transfer per input item, in order, holding
//            safe, fault, sampling and fault_event after that item.
//   cfg    : cfg_we/cfg_index/cfg_data write one register per cycle; write
//            only while no result is pending.
// Latency: a result is valid the cycle after its input transfer.
// Throughput: one item per cycle while results are taken; the whole state
//   update is one pass of compares and an increment between the state
//   registers and the result register.
// Stall: the result register holds while out_ch.ready is low; in_ch.ready
//   is low only while a result is held and not being taken.
// Reset: registers return to their reset values, state clears, safe is set,
//   no result pending.
// ----------------------------------------------------------------------------
module mains_fault_window_monitor_top #(
    parameter int SAMPLE_BITS = 10,
    parameter int TIMER_BITS  = 10
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [mfwm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mfwm_pkg::CFG_DATA_W-1:0]  cfg_data,
    mfwm_in_if.sink                               in_ch,
    mfwm_out_if.source                            out_ch
);

    localparam int CMP_W = (TIMER_BITS + 1 > mfwm_pkg::HOLD_W) ?
                           TIMER_BITS + 1 : mfwm_pkg::HOLD_W;
    localparam int PK_W  = (SAMPLE_BITS > mfwm_pkg::THRESH_W) ?
                           SAMPLE_BITS : mfwm_pkg::THRESH_W;

    // configuration
    logic                               enable_reg;
    logic [mfwm_pkg::HOLD_W-1:0]        hold_ticks_reg;
    logic [mfwm_pkg::WINDOW_W-1:0]      window_ticks_reg;
    logic [mfwm_pkg::THRESH_W-1:0]      clear_low_reg;
    logic [mfwm_pkg::THRESH_W-1:0]      clear_high_reg;
    logic [mfwm_pkg::THRESH_W-1:0]      trip_high_reg;
    logic [mfwm_pkg::THRESH_W-1:0]      trip_low_reg;

    // monitor state
    logic [TIMER_BITS-1:0]              tick_count_reg,    tick_count_next;
    logic                               window_open_reg,   window_open_next;
    logic [SAMPLE_BITS-1:0]             peak_value_reg,    peak_value_next;
    logic [mfwm_pkg::QUALIFY_W-1:0]     qualify_count_reg, qualify_count_next;
    logic                               fault_flag_reg,    fault_flag_next;
    logic                               safe_flag_reg,     safe_flag_next;
    logic                               event_next;

    // result register
    logic                               out_valid_reg;
    logic                               out_safe_reg;
    logic                               out_fault_reg;
    logic                               out_sampling_reg;
    logic                               out_event_reg;

    logic                               in_xfer;
    logic [CMP_W-1:0]                   count_inc;
    logic [CMP_W-1:0]                   hold_ext;
    logic [CMP_W-1:0]                   window_ext;
    logic [PK_W-1:0]                    peak_ext;
    logic [PK_W-1:0]                    sample_ext;
    logic                               hit;
    logic [mfwm_pkg::QUALIFY_W-1:0]     qualify_inc;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    assign count_inc  = CMP_W'(tick_count_reg) + CMP_W'(1);
    assign hold_ext   = CMP_W'(hold_ticks_reg);
    assign window_ext = CMP_W'(window_ticks_reg);
    assign peak_ext   = PK_W'(peak_value_reg);
    assign sample_ext = PK_W'(in_ch.sample);

    assign qualify_inc = qualify_count_reg + mfwm_pkg::QUALIFY_W'(1);

    always_comb
    begin
        if (fault_flag_reg)
        begin
            hit = (peak_ext <= PK_W'(clear_high_reg)) && (peak_ext >= PK_W'(clear_low_reg));
        end
        else
        begin
            hit = (peak_ext >= PK_W'(trip_high_reg)) || (peak_ext <= PK_W'(trip_low_reg));
        end
    end

    always_comb
    begin
        tick_count_next    = tick_count_reg;
        window_open_next   = window_open_reg;
        peak_value_next    = peak_value_reg;
        qualify_count_next = qualify_count_reg;
        fault_flag_next    = fault_flag_reg;
        safe_flag_next     = safe_flag_reg;
        event_next         = 1'b0;

        if (in_ch.opcode == mfwm_pkg::OP_SAMPLE)
        begin
            if (window_open_reg && (peak_ext < sample_ext))
            begin
                peak_value_next = in_ch.sample;
            end
        end
        else if (enable_reg)
        begin
            if (!window_open_reg)
            begin
                if (count_inc >= hold_ext)
                begin
                    if (in_ch.load_safe && in_ch.temp_safe)
                    begin
                        tick_count_next  = '0;
                        window_open_next = 1'b1;
                        safe_flag_next   = 1'b0;
                    end
                    else
                    begin
                        tick_count_next = hold_ext[TIMER_BITS-1:0];
                    end
                end
                else
                begin
                    tick_count_next = count_inc[TIMER_BITS-1:0];
                end
            end
            else if (count_inc >= window_ext)
            begin
                // window closes: judge the peak
                tick_count_next  = '0;
                window_open_next = 1'b0;
                peak_value_next  = '0;
                if (hit)
                begin
                    if (qualify_inc > mfwm_pkg::QUALIFY_W'(1))
                    begin
                        qualify_count_next = '0;
                        fault_flag_next    = !fault_flag_reg;
                        event_next         = 1'b1;
                    end
                    else
                    begin
                        qualify_count_next = qualify_inc;
                    end
                end
                else
                begin
                    qualify_count_next = '0;
                end
                if (!fault_flag_next)
                begin
                    safe_flag_next = 1'b1;
                end
            end
            else
            begin
                tick_count_next = count_inc[TIMER_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= mfwm_pkg::RST_ENABLE;
            hold_ticks_reg   <= mfwm_pkg::RST_HOLD_TICKS;
            window_ticks_reg <= mfwm_pkg::RST_WINDOW_TICKS;
            clear_low_reg    <= mfwm_pkg::RST_CLEAR_LOW;
            clear_high_reg   <= mfwm_pkg::RST_CLEAR_HIGH;
            trip_high_reg    <= mfwm_pkg::RST_TRIP_HIGH;
            trip_low_reg     <= mfwm_pkg::RST_TRIP_LOW;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mfwm_pkg::REG_ENABLE:       enable_reg       <= cfg_data[0];
                mfwm_pkg::REG_HOLD_TICKS:   hold_ticks_reg   <= cfg_data[mfwm_pkg::HOLD_W-1:0];
                mfwm_pkg::REG_WINDOW_TICKS: window_ticks_reg <= cfg_data[mfwm_pkg::WINDOW_W-1:0];
                mfwm_pkg::REG_CLEAR_LOW:    clear_low_reg    <= cfg_data[mfwm_pkg::THRESH_W-1:0];
                mfwm_pkg::REG_CLEAR_HIGH:   clear_high_reg   <= cfg_data[mfwm_pkg::THRESH_W-1:0];
                mfwm_pkg::REG_TRIP_HIGH:    trip_high_reg    <= cfg_data[mfwm_pkg::THRESH_W-1:0];
                mfwm_pkg::REG_TRIP_LOW:     trip_low_reg     <= cfg_data[mfwm_pkg::THRESH_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg    <= '0;
            window_open_reg   <= 1'b0;
            peak_value_reg    <= '0;
            qualify_count_reg <= '0;
            fault_flag_reg    <= 1'b0;
            safe_flag_reg     <= 1'b1;
        end
        else if (in_xfer)
        begin
            tick_count_reg    <= tick_count_next;
            window_open_reg   <= window_open_next;
            peak_value_reg    <= peak_value_next;
            qualify_count_reg <= qualify_count_next;
            fault_flag_reg    <= fault_flag_next;
            safe_flag_reg     <= safe_flag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_safe_reg     <= safe_flag_next;
            out_fault_reg    <= fault_flag_next;
            out_sampling_reg <= window_open_next;
            out_event_reg    <= event_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.safe        = out_safe_reg;
    assign out_ch.fault       = out_fault_reg;
    assign out_ch.sampling    = out_sampling_reg;
    assign out_ch.fault_event = out_event_reg;

endmodule
`default_nettype wire

>>> verif/mains_fault_window_monitor_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mains_fault_window_monitor_top_tb
// Self-checking bench for the mains fault window monitor. Tick and ADC sample
// transfers go in on in_ch; every status transfer on out_ch is checked against
// a cycle-free model of the hold timer, sampling window, peak and two-window
// trip/clear hysteresis. Directed sequences cover the thresholds, the timer
// corners and the disabled monitor; random window traffic then runs under
// three back-pressure mixes with changing register settings.
// ----------------------------------------------------------------------------
module mains_fault_window_monitor_top_tb;

    localparam int SAMPLE_BITS = 10;
    localparam int TIMER_BITS  = 10;
    localparam logic [mfwm_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef logic [mfwm_pkg::CFG_DATA_W-1:0] cfg_word_t;
    typedef logic [mfwm_pkg::CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed
    {
        logic safe;
        logic fault;
        logic sampling;
        logic fault_event;
    } status_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_word_t  cfg_data;

    mfwm_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    mfwm_out_if                             out_ch ();

    mains_fault_window_monitor_top #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIMER_BITS  (TIMER_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // model registers
    logic                             set_enable     = mfwm_pkg::RST_ENABLE;
    logic [mfwm_pkg::HOLD_W-1:0]      set_hold       = mfwm_pkg::RST_HOLD_TICKS;
    logic [mfwm_pkg::WINDOW_W-1:0]    set_window     = mfwm_pkg::RST_WINDOW_TICKS;
    logic [mfwm_pkg::THRESH_W-1:0]    set_clear_low  = mfwm_pkg::RST_CLEAR_LOW;
    logic [mfwm_pkg::THRESH_W-1:0]    set_clear_high = mfwm_pkg::RST_CLEAR_HIGH;
    logic [mfwm_pkg::THRESH_W-1:0]    set_trip_high  = mfwm_pkg::RST_TRIP_HIGH;
    logic [mfwm_pkg::THRESH_W-1:0]    set_trip_low   = mfwm_pkg::RST_TRIP_LOW;

    // model state
    logic [TIMER_BITS-1:0]            tick_cnt    = '0;
    logic                             window_on   = 1'b0;
    sample_t                          peak        = '0;
    logic [mfwm_pkg::QUALIFY_W-1:0]   qualify_cnt = '0;
    logic                             fault_on    = 1'b0;
    logic                             safe_on     = 1'b1;

    status_t pending_status[$];
    bit      failed       = 1'b0;
    int      tx_idle_pct  = 0;
    int      rx_stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic status_t predict_status(mfwm_pkg::opcode_t op, sample_t smp,
                                               logic ld_ok, logic tmp_ok);
        int   nxt;
        logic hit;
        logic evt;
        evt = 1'b0;
        if (op == mfwm_pkg::OP_SAMPLE)
        begin
            if (window_on && peak < smp)
                peak = smp;
        end
        else if (set_enable)
        begin
            nxt = int'(tick_cnt) + 1;
            if (!window_on)
            begin
                if (nxt >= int'(set_hold))
                begin
                    if (ld_ok && tmp_ok)
                    begin
                        tick_cnt  = '0;
                        window_on = 1'b1;
                        safe_on   = 1'b0;
                    end
                    else
                        tick_cnt = TIMER_BITS'(set_hold);
                end
                else
                    tick_cnt = TIMER_BITS'(nxt);
            end
            else if (nxt >= int'(set_window))
            begin
                tick_cnt  = '0;
                window_on = 1'b0;
                if (fault_on)
                    hit = (peak <= set_clear_high) && (peak >= set_clear_low);
                else
                    hit = (peak >= set_trip_high) || (peak <= set_trip_low);
                if (hit)
                begin
                    qualify_cnt = qualify_cnt + mfwm_pkg::QUALIFY_W'(1);
                    if (qualify_cnt > 1)
                    begin
                        qualify_cnt = '0;
                        fault_on    = ~fault_on;
                        evt         = 1'b1;
                    end
                end
                else
                    qualify_cnt = '0;
                if (!fault_on)
                    safe_on = 1'b1;
                peak = '0;
            end
            else
                tick_cnt = TIMER_BITS'(nxt);
        end
        return '{safe_on, fault_on, window_on, evt};
    endfunction

    // called at a rising edge; returns at the edge that takes the transfer
    task automatic send_item(mfwm_pkg::opcode_t op, sample_t smp, logic ld_ok,
                             logic tmp_ok);
        bit taken;
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.sample    <= smp;
        in_ch.load_safe <= ld_ok;
        in_ch.temp_safe <= tmp_ok;
        do
        begin
            @(negedge clk);
            taken = in_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        pending_status.push_back(predict_status(op, smp, ld_ok, tmp_ok));
    endtask

    // waits for the block to go idle, then writes one register
    task automatic write_reg(cfg_index_t idx, cfg_word_t val);
        in_ch.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mfwm_pkg::REG_ENABLE:       set_enable     = val[0];
            mfwm_pkg::REG_HOLD_TICKS:   set_hold       = val[mfwm_pkg::HOLD_W-1:0];
            mfwm_pkg::REG_WINDOW_TICKS: set_window     = val[mfwm_pkg::WINDOW_W-1:0];
            mfwm_pkg::REG_CLEAR_LOW:    set_clear_low  = val[mfwm_pkg::THRESH_W-1:0];
            mfwm_pkg::REG_CLEAR_HIGH:   set_clear_high = val[mfwm_pkg::THRESH_W-1:0];
            mfwm_pkg::REG_TRIP_HIGH:    set_trip_high  = val[mfwm_pkg::THRESH_W-1:0];
            mfwm_pkg::REG_TRIP_LOW:     set_trip_low   = val[mfwm_pkg::THRESH_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // one-tick windows against the reset thresholds: set and clear the fault
    task automatic test_fault_hysteresis();
        write_reg(mfwm_pkg::REG_HOLD_TICKS, 10'd1);
        write_reg(mfwm_pkg::REG_WINDOW_TICKS, 10'd1);
        send_item(mfwm_pkg::OP_SAMPLE, 10'd500, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b0, 1'b1);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b0);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_SAMPLE, 10'd1023, 1'b0, 1'b0);
        send_item(mfwm_pkg::OP_SAMPLE, 10'd0, 1'b0, 1'b0);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_SAMPLE, 10'd210, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_SAMPLE, 10'd199, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_SAMPLE, 10'd200, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_SAMPLE, 10'd400, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
    endtask

    // zero limits, lowered hold, disabled monitor, masking, unmapped index
    task automatic test_timer_corners();
        write_reg(mfwm_pkg::REG_HOLD_TICKS, 10'd0);
        write_reg(mfwm_pkg::REG_WINDOW_TICKS, 10'd0);
        send_item(mfwm_pkg::OP_TICK, 10'd1023, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
        write_reg(mfwm_pkg::REG_HOLD_TICKS, 10'd10);
        write_reg(mfwm_pkg::REG_WINDOW_TICKS, 10'd15);
        repeat (3) send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b0, 1'b0);
        write_reg(mfwm_pkg::REG_HOLD_TICKS, 10'd2);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b0, 1'b1);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
        write_reg(mfwm_pkg::REG_ENABLE, 10'h3FE);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
        send_item(mfwm_pkg::OP_SAMPLE, 10'd777, 1'b0, 1'b0);
        write_reg(mfwm_pkg::REG_ENABLE, 10'h001);
        write_reg(mfwm_pkg::REG_WINDOW_TICKS, 10'h3F1);
        write_reg(REG_UNMAPPED, 10'h155);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
        write_reg(mfwm_pkg::REG_HOLD_TICKS, 10'd1023);
        send_item(mfwm_pkg::OP_TICK, 10'd0, 1'b1, 1'b1);
    endtask

    task automatic randomize_settings(bit extremes);
        cfg_word_t lo;
        cfg_word_t span;
        if (extremes)
        begin
            write_reg(mfwm_pkg::REG_ENABLE, 10'd1);
            write_reg(mfwm_pkg::REG_HOLD_TICKS, 10'd0);
            write_reg(mfwm_pkg::REG_WINDOW_TICKS, 10'd15);
            write_reg(mfwm_pkg::REG_CLEAR_LOW, 10'd0);
            write_reg(mfwm_pkg::REG_CLEAR_HIGH, 10'd1023);
            write_reg(mfwm_pkg::REG_TRIP_HIGH, 10'd1023);
            write_reg(mfwm_pkg::REG_TRIP_LOW, 10'd0);
        end
        else
        begin
            write_reg(mfwm_pkg::REG_ENABLE, ($urandom_range(9) == 0) ? 10'h3FE : 10'h001);
            case ($urandom_range(9))
                0:       write_reg(mfwm_pkg::REG_HOLD_TICKS, 10'd0);
                9:       write_reg(mfwm_pkg::REG_HOLD_TICKS,
                                   cfg_word_t'($urandom_range(5, 40)));
                default: write_reg(mfwm_pkg::REG_HOLD_TICKS,
                                   cfg_word_t'($urandom_range(1, 4)));
            endcase
            case ($urandom_range(9))
                0:       write_reg(mfwm_pkg::REG_WINDOW_TICKS, 10'd0);
                9:       write_reg(mfwm_pkg::REG_WINDOW_TICKS,
                                   cfg_word_t'($urandom_range(5, 15)));
                default: write_reg(mfwm_pkg::REG_WINDOW_TICKS,
                                   cfg_word_t'($urandom_range(1, 4)));
            endcase
            lo   = cfg_word_t'($urandom_range(100, 500));
            span = cfg_word_t'($urandom_range(0, 400));
            write_reg(mfwm_pkg::REG_CLEAR_LOW, lo);
            write_reg(mfwm_pkg::REG_CLEAR_HIGH, lo + span - 10'd20);
            write_reg(mfwm_pkg::REG_TRIP_HIGH, cfg_word_t'($urandom_range(250, 1023)));
            write_reg(mfwm_pkg::REG_TRIP_LOW, cfg_word_t'($urandom_range(0, 400)));
            if ($urandom_range(3) == 0)
                write_reg(REG_UNMAPPED, cfg_word_t'($urandom));
        end
    endtask

    // mostly well-formed windows: safe ticks to open one, samples near the thresholds,
    // at the ends or random while it is open, a few stray samples and unsafe ticks
    task automatic drive_window_traffic(int count);
        sample_t smp;
        sample_t nudge;
        repeat (count)
        begin
            nudge = sample_t'($urandom_range(2));
            nudge = nudge - sample_t'(1);
            case ($urandom_range(7))
                0:       smp = '0;
                1:       smp = '1;
                2:       smp = set_trip_low + nudge;
                3:       smp = set_trip_high + nudge;
                4:       smp = set_clear_low + nudge;
                5:       smp = set_clear_high + nudge;
                default: smp = sample_t'($urandom);
            endcase
            if (window_on)
            begin
                if ($urandom_range(99) < 55)
                    send_item(mfwm_pkg::OP_SAMPLE, smp, 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                else
                    send_item(mfwm_pkg::OP_TICK, sample_t'($urandom),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            else if ($urandom_range(99) < 10)
                send_item(mfwm_pkg::OP_SAMPLE, sample_t'($urandom),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                send_item(mfwm_pkg::OP_TICK, sample_t'($urandom),
                          $urandom_range(99) < 88, $urandom_range(99) < 88);
        end
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int k = 0; k < 3; k++)
        begin
            randomize_settings(k == 0 && tx_pct == 0);
            drive_window_traffic(100);
        end
    endtask

    initial
    begin
        status_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (pending_status.size() == 0)
                begin
                    $error("unexpected transfer: safe=%0b fault=%0b sampling=%0b event=%0b",
                           out_ch.safe, out_ch.fault, out_ch.sampling, out_ch.fault_event);
                    failed = 1'b1;
                end
                else
                begin
                    want = pending_status.pop_front();
                    if (out_ch.safe !== want.safe)
                    begin
                        $error("safe: expected %0b, got %0b", want.safe, out_ch.safe);
                        failed = 1'b1;
                    end
                    if (out_ch.fault !== want.fault)
                    begin
                        $error("fault: expected %0b, got %0b", want.fault, out_ch.fault);
                        failed = 1'b1;
                    end
                    if (out_ch.sampling !== want.sampling)
                    begin
                        $error("sampling: expected %0b, got %0b", want.sampling,
                               out_ch.sampling);
                        failed = 1'b1;
                    end
                    if (out_ch.fault_event !== want.fault_event)
                    begin
                        $error("fault_event: expected %0b, got %0b", want.fault_event,
                               out_ch.fault_event);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= mfwm_pkg::REG_ENABLE;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.opcode    <= mfwm_pkg::OP_TICK;
        in_ch.sample    <= '0;
        in_ch.load_safe <= 1'b0;
        in_ch.temp_safe <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct  = 9;
        rx_stall_pct = 68;
        test_fault_hysteresis();
        test_timer_corners();
        test_random_traffic(9, 68);
        test_random_traffic(68, 9);
        test_random_traffic(0, 0);

        in_ch.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (!failed)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/mfwm_pkg.sv
rtl/core/mfwm_if.sv
rtl/core/mains_fault_window_monitor_top.sv
verif/mains_fault_window_monitor_top_tb.sv
